### hw/rtl/hfdl_pkg.sv
// Shared constants for the Hermite fractional delay line.
// No dependencies; imported by hermite_fractional_delay_line.
package hfdl_pkg;

    localparam int DEF_STORE_DEPTH = 65536;
    localparam int DEF_SAMPLE_BITS = 24;

    localparam int CFG_BITS   = 17;
    localparam logic [CFG_BITS-1:0] CFG_RESET = 17'd65536;
    localparam int MIN_LENGTH = 4;

    localparam int DELAY_BITS = 32;
    localparam int FRAC_BITS  = 16;
    localparam int GUARD_BITS = 8;

endpackage

### hw/rtl/hermite_fractional_delay_line.sv
// Circular delay line with a 4-point third-order Hermite fractional read tap.
// Depends on hfdl_pkg (constants); holds the sample memory and the datapath.
//
// Each input transaction carries one sample and a Q16.16 delay. The block
// writes the sample at the next write position (wrapping at the programmed
// buffer length) in the cycle the transaction is accepted, then reads the
// four neighbouring samples around the integer delay from a single-port
// sample memory, one per cycle, and evaluates the Hermite polynomial in
// Horner form with one shared multiplier (three multiply/round steps).
// The block takes no new item until the last one is through; the
// result is held in an output register, so a stalled result only holds the
// block once the next result is ready. The delay saturates to
// [1, length-2] and the output to the signed sample range. The buffer
// length is clamped to [4, STORE_DEPTH]. After reset the memory is swept
// to zero, one entry per cycle, across the whole store; no input
// transaction is taken during that pass, configuration writes are.
// Write buffer_length only while no transaction is in flight.
module hermite_fractional_delay_line #(
    parameter int STORE_DEPTH = hfdl_pkg::DEF_STORE_DEPTH,
    parameter int SAMPLE_BITS = hfdl_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration
    input  logic                                 i_cfg_we,
    input  logic [hfdl_pkg::CFG_BITS-1:0]        i_cfg_wdata,
    // input channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0]        i_sample_in,
    input  logic [hfdl_pkg::DELAY_BITS-1:0]      i_delay,
    // output channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [SAMPLE_BITS-1:0]        o_sample_out
);
    import hfdl_pkg::*;

    // address, length and datapath widths
    localparam int AW = $clog2(STORE_DEPTH);
    localparam int LW = $clog2(STORE_DEPTH + 1);
    localparam int EW = (LW > CFG_BITS) ? LW : CFG_BITS;
    localparam int DW = (LW + FRAC_BITS > DELAY_BITS) ? LW + FRAC_BITS : DELAY_BITS;
    localparam int TW = AW + 2;
    localparam int W  = SAMPLE_BITS + 14;
    localparam int P  = W + FRAC_BITS + 1;
    localparam int RST_LEN = (STORE_DEPTH < 65536) ? STORE_DEPTH : 65536;
    localparam int RSH = FRAC_BITS + GUARD_BITS;

    localparam logic signed [P-1:0] RND_F  = P'(longint'(1) <<< (FRAC_BITS - 1));
    localparam logic signed [P-1:0] RND_FG = P'(longint'(1) <<< (RSH - 1));
    localparam logic signed [P-1:0] SAT_HI = P'((longint'(1) <<< (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [P-1:0] SAT_LO = -SAT_HI - P'(1);

    // sequencer states
    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_ADDR  = 4'd2;
    localparam logic [3:0] ST_RA    = 4'd3;
    localparam logic [3:0] ST_RB    = 4'd4;
    localparam logic [3:0] ST_RC    = 4'd5;
    localparam logic [3:0] ST_RD    = 4'd6;
    localparam logic [3:0] ST_COEF  = 4'd7;
    localparam logic [3:0] ST_M1    = 4'd8;
    localparam logic [3:0] ST_A1    = 4'd9;
    localparam logic [3:0] ST_M2    = 4'd10;
    localparam logic [3:0] ST_A2    = 4'd11;
    localparam logic [3:0] ST_M3    = 4'd12;
    localparam logic [3:0] ST_FIN   = 4'd13;

    logic [SAMPLE_BITS-1:0] mem [STORE_DEPTH];

    logic [3:0]                  r_state, n_state;
    logic [AW-1:0]               r_clr_addr;
    logic [CFG_BITS-1:0]         r_cfg;
    logic [AW-1:0]               r_wp;
    logic [AW-1:0]               r_pos;
    logic [LW-1:0]               r_len;
    logic [DELAY_BITS-1:0]       r_delay;
    logic signed [TW-1:0]        r_tap;
    logic [FRAC_BITS-1:0]        r_frac;
    logic [SAMPLE_BITS-1:0]      r_rd_data;
    logic signed [SAMPLE_BITS-1:0] r_sa, r_sb, r_sc;
    logic signed [W-1:0]         r_a, r_b, r_slope0, r_s;
    logic signed [P-1:0]         r_prod;
    logic                        r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_data;

    // effective buffer length
    logic [EW-1:0]  cfg_e, eff_e;
    logic [LW-1:0]  eff_len;
    // write position
    logic [AW:0]    pos_inc;
    logic [AW-1:0]  pos_next;
    logic           accept;
    // memory port
    logic                   wr_en, rd_en;
    logic [AW-1:0]          wr_addr, rd_addr;
    logic [SAMPLE_BITS-1:0] wr_data;
    // delay clamp and taps
    logic [DW-1:0]          d_e, d_lo, d_hi, d_c;
    logic [AW-1:0]          n_int;
    logic signed [TW-1:0]   tap0, tap_w, len_s;
    // coefficients
    logic signed [W-1:0]    sa_w, sb_w, sc_w, sd_w;
    // multiply and round
    logic signed [W-1:0]    mul_x;
    logic signed [FRAC_BITS:0] mul_y;
    logic signed [P-1:0]    s1_t, s2_t, fin_t, fin_sat;
    logic                   out_free;

    // clamp the programmed length to [4, STORE_DEPTH]
    always_comb begin
        cfg_e = EW'(r_cfg);
        if (cfg_e < EW'(MIN_LENGTH)) begin
            eff_e = EW'(MIN_LENGTH);
        end else if (cfg_e > EW'(STORE_DEPTH)) begin
            eff_e = EW'(STORE_DEPTH);
        end else begin
            eff_e = cfg_e;
        end
        eff_len = eff_e[LW-1:0];
    end

    // advance and wrap the write position
    assign pos_inc  = {1'b0, r_wp} + (AW+1)'(1);
    assign pos_next = (pos_inc >= (AW+1)'(eff_len)) ? '0 : pos_inc[AW-1:0];

    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid && !o_in_stall;

    // saturate the delay and find the newest tap (A)
    always_comb begin
        d_e   = DW'(r_delay);
        d_lo  = DW'(1) << FRAC_BITS;
        d_hi  = DW'(r_len - LW'(2)) << FRAC_BITS;
        if (d_e < d_lo) begin
            d_c = d_lo;
        end else if (d_e > d_hi) begin
            d_c = d_hi;
        end else begin
            d_c = d_e;
        end
        n_int = d_c[FRAC_BITS +: AW];
        tap0  = $signed(TW'(r_pos)) + TW'(1) - $signed(TW'(n_int));
    end

    // wrap the current tap once by the buffer length
    assign len_s = $signed(TW'(r_len));
    assign tap_w = (r_tap < 0) ? r_tap + len_s : r_tap;

    // memory port: clearing sweep or sample write, and tap reads
    always_comb begin
        wr_en   = (r_state == ST_CLEAR) || accept;
        wr_addr = (r_state == ST_CLEAR) ? r_clr_addr : pos_next;
        wr_data = (r_state == ST_CLEAR) ? '0 : i_sample_in;
        rd_en   = r_state inside {ST_RA, ST_RB, ST_RC, ST_RD};
        rd_addr = tap_w[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // Hermite terms, scaled by 2^GUARD_BITS:
    //   a = (-A + 3B - 3C + D) / 2, b = (-2A + 5B - 4C + D) / 2, slope0 = (C - A) / 2
    assign sa_w = W'(r_sa);
    assign sb_w = W'(r_sb);
    assign sc_w = W'(r_sc);
    assign sd_w = W'($signed(r_rd_data));

    // one shared multiplier for the three Horner steps
    assign mul_x = (r_state == ST_M1) ? r_a : r_s;
    assign mul_y = $signed({1'b0, r_frac});

    assign s1_t  = (r_prod - (P'(r_b) <<< FRAC_BITS) + RND_F) >>> FRAC_BITS;
    assign s2_t  = (r_prod + (P'(r_slope0) <<< FRAC_BITS) + RND_F) >>> FRAC_BITS;
    assign fin_t = (r_prod + (P'(r_sb) <<< RSH) + RND_FG) >>> RSH;

    always_comb begin
        if (fin_t > SAT_HI) begin
            fin_sat = SAT_HI;
        end else if (fin_t < SAT_LO) begin
            fin_sat = SAT_LO;
        end else begin
            fin_sat = fin_t;
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == AW'(STORE_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_ADDR;
                end
            end
            ST_ADDR: n_state = ST_RA;
            ST_RA:   n_state = ST_RB;
            ST_RB:   n_state = ST_RC;
            ST_RC:   n_state = ST_RD;
            ST_RD:   n_state = ST_COEF;
            ST_COEF: n_state = ST_M1;
            ST_M1:   n_state = ST_A1;
            ST_A1:   n_state = ST_M2;
            ST_M2:   n_state = ST_A2;
            ST_A2:   n_state = ST_M3;
            ST_M3:   n_state = ST_FIN;
            ST_FIN: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_cfg       <= CFG_RESET;
            r_wp        <= AW'(RST_LEN - 1);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            if (accept) begin
                r_wp <= pos_next;
            end
            if (r_state == ST_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pos   <= pos_next;
            r_len   <= eff_len;
            r_delay <= i_delay;
        end
        case (r_state)
            ST_ADDR: begin
                r_tap  <= tap0;
                r_frac <= d_c[FRAC_BITS-1:0];
            end
            ST_RA: r_tap <= r_tap - TW'(1);
            ST_RB: begin
                r_sa  <= $signed(r_rd_data);
                r_tap <= r_tap - TW'(1);
            end
            ST_RC: begin
                r_sb  <= $signed(r_rd_data);
                r_tap <= r_tap - TW'(1);
            end
            ST_RD: r_sc <= $signed(r_rd_data);
            ST_COEF: begin
                r_a      <= (sd_w - sa_w + W'(3) * (sb_w - sc_w)) <<< (GUARD_BITS - 1);
                r_b      <= (sd_w - W'(2) * sa_w + W'(5) * sb_w - W'(4) * sc_w)
                            <<< (GUARD_BITS - 1);
                r_slope0 <= (sc_w - sa_w) <<< (GUARD_BITS - 1);
            end
            ST_M1, ST_M2, ST_M3: r_prod <= P'(mul_x) * P'(mul_y);
            ST_A1: r_s <= s1_t[W-1:0];
            ST_A2: r_s <= s2_t[W-1:0];
            ST_FIN: begin
                if (out_free) begin
                    r_out_data <= fin_sat[SAMPLE_BITS-1:0];
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out_data;

`ifndef SYNTHESIS
    // an accepted transaction holds the input side on the next cycle
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_in_stall)
        else $error("input accepted while an item is in flight");

    // a new result appears only out of the final Horner step
    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ST_FIN)
        else $error("output loaded outside the final step");

    // every tap read lands inside the buffer in use
    a_tap_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en |-> (TW'(rd_addr) < TW'(r_len)) && (tap_w >= 0))
        else $error("tap address outside the buffer");

    // the newest tap never runs ahead of the sample just written
    a_tap_behind_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RA) |-> r_tap <= $signed(TW'(r_pos)))
        else $error("newest tap ahead of write position");

    // no result is shown before the clearing sweep ends
    a_no_out_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !r_out_valid)
        else $error("result valid during clearing sweep");
`endif

endmodule

### test/hermite_fractional_delay_line_chk.sv
`timescale 1ns / 1ps
// Scoreboard for hermite_fractional_delay_line: mirrors the sample store,
// computes each interpolated tap and compares it with the output channel.
// Depends on hfdl_pkg for widths, fraction/guard sizes and the reset length.
module hermite_fractional_delay_line_chk (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_cfg_we,
    input  logic [hfdl_pkg::CFG_BITS-1:0]             i_cfg_wdata,
    input  logic                                      i_in_valid,
    input  logic                                      i_in_stall,
    input  logic signed [hfdl_pkg::DEF_SAMPLE_BITS-1:0] i_sample_in,
    input  logic [hfdl_pkg::DELAY_BITS-1:0]           i_delay,
    input  logic                                      i_out_valid,
    input  logic                                      i_out_stall,
    input  logic signed [hfdl_pkg::DEF_SAMPLE_BITS-1:0] i_sample_out,
    output int                                        o_taps_due,
    output int                                        o_mismatches
);

    localparam int     SB     = hfdl_pkg::DEF_SAMPLE_BITS;
    localparam int     DEPTH  = hfdl_pkg::DEF_STORE_DEPTH;
    localparam int     FB     = hfdl_pkg::FRAC_BITS;
    localparam int     GB     = hfdl_pkg::GUARD_BITS;
    localparam longint ONE_F  = longint'(1) << FB;
    localparam longint SCALE  = longint'(1) << GB;
    localparam longint HALF   = longint'(1) << (GB - 1);
    localparam longint TOP    = (longint'(1) << (SB - 1)) - 1;

    logic signed [SB-1:0] sample_mem [DEPTH];
    logic signed [SB-1:0] interp_q [$];
    int                   length_reg;
    int                   wr_pos;

    function automatic int eff_length(int v);
        if (v < hfdl_pkg::MIN_LENGTH)
            return hfdl_pkg::MIN_LENGTH;
        if (v > DEPTH)
            return DEPTH;
        return v;
    endfunction

    function automatic int wrap(int i, int len);
        return (i < 0) ? i + len : i;
    endfunction

    // Floor shift with a half added first: rounds half toward plus infinity.
    function automatic longint round_q(longint x, int s);
        return (x + (longint'(1) << (s - 1))) >>> s;
    endfunction

    // Hermite evaluation in Horner form, guard bits below the sample LSB.
    function automatic logic signed [SB-1:0] hermite_interp(
        longint sa, longint sb, longint sc, longint sd, longint f);
        longint slope0, slope1, v, w, a, b, s1, s2, r;
        slope0 = (sc - sa) * HALF;
        slope1 = (sd - sb) * HALF;
        v      = (sb - sc) * SCALE;
        w      = slope0 + v;
        a      = w + v + slope1;
        b      = w + a;
        s1     = round_q(a * f - b * ONE_F, FB);
        s2     = round_q(s1 * f + slope0 * ONE_F, FB);
        r      = round_q(s2 * f + sb * SCALE * ONE_F, FB + GB);
        if (r > TOP)
            r = TOP;
        else if (r < -TOP - 1)
            r = -TOP - 1;
        return r[SB-1:0];
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] sample_out mismatch: %s", $realtime, msg);
        o_mismatches = o_mismatches + 1;
    endtask

    always @(posedge i_clk) begin : model
        int                   len, pos, n, ia;
        longint               d, f, hi;
        logic signed [SB-1:0] want;
        if (!i_rst_n) begin
            foreach (sample_mem[k])
                sample_mem[k] = '0;
            length_reg   = int'(hfdl_pkg::CFG_RESET);
            wr_pos       = eff_length(length_reg) - 1;
            interp_q.delete();
            o_mismatches = 0;
        end else begin
            if (i_cfg_we)
                length_reg = int'(i_cfg_wdata);
            if (i_in_valid && !i_in_stall) begin
                // write first, then read the four taps around the delay
                len = eff_length(length_reg);
                pos = wr_pos + 1;
                if (pos >= len)
                    pos = 0;
                wr_pos = pos;
                sample_mem[pos] = i_sample_in;
                d  = longint'(i_delay);
                hi = longint'(len - 2) << FB;
                if (d < ONE_F)
                    d = ONE_F;
                if (d > hi)
                    d = hi;
                n  = int'(d >>> FB);
                f  = d & (ONE_F - 1);
                ia = pos - n + 1;
                interp_q.push_back(hermite_interp(
                    sample_mem[wrap(ia, len)], sample_mem[wrap(ia - 1, len)],
                    sample_mem[wrap(ia - 2, len)], sample_mem[wrap(ia - 3, len)], f));
            end
            if (i_out_valid && !i_out_stall) begin
                if (interp_q.size() == 0) begin
                    report_mismatch($sformatf("got %0d with nothing due", i_sample_out));
                end else begin
                    want = interp_q.pop_front();
                    if (i_sample_out !== want)
                        report_mismatch($sformatf("got %0d, want %0d", i_sample_out, want));
                end
            end
        end
        o_taps_due <= interp_q.size();
    end

endmodule

### test/hermite_fractional_delay_line_tb.sv
`timescale 1ns / 1ps
// Top-level bench for hermite_fractional_delay_line: drives samples and delays,
// programs the buffer length between phases, and gives the verdict.
// Depends on hfdl_pkg and hermite_fractional_delay_line_chk (the scoreboard).
module hermite_fractional_delay_line_tb;

    localparam int SB          = hfdl_pkg::DEF_SAMPLE_BITS;
    localparam int DB          = hfdl_pkg::DELAY_BITS;
    localparam int CB          = hfdl_pkg::CFG_BITS;
    localparam int DEPTH       = hfdl_pkg::DEF_STORE_DEPTH;
    // The sweep after reset alone keeps the input stalled while it clears the store.
    localparam int QUIET_LIMIT = 4 * DEPTH;
    localparam int DRAIN       = 32;
    localparam int PHASES      = 9;
    localparam int PHASE_ITEMS = 50;

    localparam logic signed [SB-1:0] S_MAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] S_MIN = {1'b1, {(SB-1){1'b0}}};

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_cfg_we     = 1'b0;
    logic [CB-1:0]        i_cfg_wdata  = '0;
    logic                 i_in_valid   = 1'b0;
    logic signed [SB-1:0] i_sample_in  = '0;
    logic [DB-1:0]        i_delay      = '0;
    logic                 i_out_stall  = 1'b0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic signed [SB-1:0] o_sample_out;

    int                   taps_due;
    int                   mismatches;
    int                   cur_len      = DEPTH;
    int                   stall_left   = 0;
    bit                   idle_on      = 1'b1;
    logic signed [SB-1:0] walk         = '0;

    wire in_fire  = i_in_valid && !o_in_stall;
    wire out_fire = o_out_valid && !i_out_stall;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    hermite_fractional_delay_line dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_sample_in  (i_sample_in),
        .i_delay      (i_delay),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_sample_out (o_sample_out)
    );

    hermite_fractional_delay_line_chk chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_sample_in  (i_sample_in),
        .i_delay      (i_delay),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_sample_out (o_sample_out),
        .o_taps_due   (taps_due),
        .o_mismatches (mismatches)
    );

    // Output-side back-pressure: random bursts of stalled cycles,
    // dropped entirely once idling is switched off for the last phase.
    always @(posedge i_clk) begin
        if (!i_rst_n || !idle_on) begin
            i_out_stall <= 1'b0;
            stall_left  = 0;
        end else if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left  = stall_left - 1;
        end else if ($urandom_range(0, 3) == 0) begin
            i_out_stall <= 1'b1;
            stall_left  = $urandom_range(0, 2);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Present one transaction and hold it until the block takes it. Valid
    // stays high into the next call unless that call opens a gap first.
    task automatic send_item(logic signed [SB-1:0] s, logic [DB-1:0] d);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_sample_in <= s;
        i_delay     <= d;
        do
            @(posedge i_clk);
        while (o_in_stall);
    endtask

    // Drop valid and wait until every interpolated sample has come out.
    // The due count is registered, so let it update before trusting it.
    task automatic finish_phase();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (taps_due != 0)
            @(posedge i_clk);
    endtask

    task automatic write_length(int v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= CB'(v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_len = (v < hfdl_pkg::MIN_LENGTH) ? hfdl_pkg::MIN_LENGTH :
                  (v > DEPTH) ? DEPTH : v;
    endtask

    // Samples: some extremes, a bounded random walk so that neighbouring
    // taps are correlated like audio, and plain full-width noise.
    function automatic logic signed [SB-1:0] rand_sample();
        int     pick;
        longint nxt;
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            case ($urandom_range(0, 3))
                0: begin
                    walk = S_MAX;
                end
                1: begin
                    walk = S_MIN;
                end
                2: begin
                    walk = '0;
                end
                default: begin
                    walk = '1;
                end
            endcase
        end else if (pick < 50) begin
            nxt = longint'(walk) + longint'($urandom_range(0, 131072)) - 65536;
            if (nxt > longint'(S_MAX))
                nxt = longint'(S_MAX);
            if (nxt < longint'(S_MIN))
                nxt = longint'(S_MIN);
            walk = nxt[SB-1:0];
        end else begin
            walk = SB'($urandom);
        end
        return walk;
    endfunction

    // Delays: short ones (the largest share) that land on recently written samples,
    // plus raw words, sub-sample values, range edges and uniform taps.
    function automatic logic [DB-1:0] pick_delay(int len);
        int pick, nmax;
        pick = $urandom_range(0, 99);
        nmax = len - 2;
        if (pick < 40)
            return {16'($urandom_range(1, (nmax < 48) ? nmax : 48)),
                    16'($urandom_range(0, 65535))};
        if (pick < 55)
            return $urandom;
        if (pick < 65)
            return DB'($urandom_range(0, 65535));
        if (pick < 75) begin
            case ($urandom_range(0, 3))
                0: begin
                    return 32'h0001_0000;
                end
                1: begin
                    return {16'(nmax), 16'h0000};
                end
                2: begin
                    return 32'hFFFF_FFFF;
                end
                default: begin
                    return {16'(nmax), 16'hFFFF};
                end
            endcase
        end
        return {16'($urandom_range(1, nmax)), 16'($urandom_range(0, 65535))};
    endfunction

    // Watchdog: end the run after too many cycles with no transaction on
    // either channel.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (in_fire || out_fire || !i_rst_n)
                quiet = 0;
            else
                quiet = quiet + 1;
        end
        $display("hermite_fractional_delay_line_tb NOT OK");
        $finish;
    end

    initial begin : stimulus
        int phase, len_req;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset length: sub-sample delays saturate up to one sample, an
        // exact one, fractions, and the all-ones delay saturating at the top.
        send_item(S_MAX, 32'h0000_0000);
        send_item(S_MIN, 32'h0000_FFFF);
        send_item(S_MAX, 32'h0001_0000);
        send_item(S_MIN, 32'h0001_8000);
        send_item(S_MAX, 32'h0002_FFFF);
        send_item(S_MIN, 32'hFFFF_FFFF);
        send_item('0,    32'hFFFE_0000);
        send_item('1,    32'h0003_4000);
        finish_phase();

        // Length below range clamps to four; the write position wraps on
        // the next write. Plateaus of full-scale samples read half way
        // between drive the curve past the sample range on both sides.
        write_length(0);
        send_item('0,    32'h0002_0000);
        send_item(S_MAX, 32'h0002_8000);
        send_item(S_MAX, 32'h0000_0000);
        send_item('0,    32'h0001_8000);
        send_item(S_MIN, 32'h0002_0000);
        send_item(S_MIN, 32'h0001_0000);
        send_item('0,    32'h0001_8000);
        finish_phase();

        // Length above range clamps to the full store.
        write_length(131071);
        send_item(S_MAX, 32'hFFFE_0000);
        send_item(S_MIN, 32'hFFFD_FFFF);
        send_item(24'sh5A5A5A, 32'h0001_0001);
        finish_phase();

        write_length(5);
        send_item(S_MAX, 32'h0003_FFFF);
        send_item(S_MIN, 32'h0003_0000);
        send_item('1,    32'h0001_C000);
        send_item(24'sd1, 32'h0004_0000);

        // Random phases, each under a fresh buffer length; the last one
        // runs with no gaps and no back-pressure.
        for (phase = 0; phase < PHASES; phase++) begin
            finish_phase();
            case (phase)
                0: begin
                    len_req = DEPTH;
                end
                1: begin
                    len_req = hfdl_pkg::MIN_LENGTH;
                end
                2: begin
                    len_req = $urandom_range(5, 40);
                end
                3: begin
                    len_req = $urandom_range(0, 3);
                end
                4: begin
                    len_req = $urandom_range(4, 131071);
                end
                5: begin
                    len_req = $urandom_range(DEPTH + 1, 131071);
                end
                6: begin
                    len_req = $urandom_range(4, 300);
                end
                7: begin
                    len_req = $urandom_range(4, 1024);
                end
                default: begin
                    len_req = $urandom_range(4, 64);
                    idle_on = 1'b0;
                end
            endcase
            write_length(len_req);
            repeat (PHASE_ITEMS) send_item(rand_sample(), pick_delay(cur_len));
        end

        finish_phase();
        repeat (DRAIN) @(posedge i_clk);
        if (mismatches == 0)
            $display("hermite_fractional_delay_line_tb OK");
        else
            $display("hermite_fractional_delay_line_tb NOT OK");
        $finish;
    end

endmodule

### hermite_fractional_delay_line.f
hw/rtl/hfdl_pkg.sv
hw/rtl/hermite_fractional_delay_line.sv
test/hermite_fractional_delay_line_chk.sv
test/hermite_fractional_delay_line_tb.sv
